FILE: rtl/kcs_bmc_host_interface_defines.svh
// ----------------------------------------------------------------------------
// KCS mailbox assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef KCS_BMC_HOST_INTERFACE_DEFINES_SVH
`define KCS_BMC_HOST_INTERFACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/kcs_pkg.sv
// ----------------------------------------------------------------------------
// KCS mailbox package
// Word map, status flag masks, request and response codes, channel bundles.
// ----------------------------------------------------------------------------
package kcs_pkg;

   localparam int REG_COUNT     = 64;
   localparam int LADR12L_RESET = 96;

   localparam int IDX_W      = 10;
   localparam int CH_W       = 2;
   localparam int WORD_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int NCHAN      = 3;
   localparam int RAM_ADDR_W = $clog2(REG_COUNT);

   // Word indexes of the registers with behaviour of their own
   localparam logic [IDX_W-1:0] W_HICR0   = IDX_W'(0);
   localparam logic [IDX_W-1:0] W_HICR2   = IDX_W'(2);
   localparam logic [IDX_W-1:0] W_HICR4   = IDX_W'(4);
   localparam logic [IDX_W-1:0] W_LADR12L = IDX_W'(8);
   localparam logic [IDX_W-1:0] W_IDR     = IDX_W'(9);
   localparam logic [IDX_W-1:0] W_ODR     = IDX_W'(12);
   localparam logic [IDX_W-1:0] W_STR     = IDX_W'(15);
   localparam logic [IDX_W-1:0] W_STR_END = IDX_W'(15 + NCHAN - 1);

   localparam logic [IDX_W:0] REG_COUNT_IDX = (IDX_W + 1)'(REG_COUNT);

   // Control bit positions
   localparam int HICR0_EN_LSB  = 5;
   localparam int HICR2_IE_LSB  = 1;
   localparam int HICR4_KCS_BIT = 2;

   // Status register flags
   localparam logic [BYTE_W-1:0] STR_OBF  = 8'h01;
   localparam logic [BYTE_W-1:0] STR_IBF  = 8'h02;
   localparam logic [BYTE_W-1:0] STR_CD   = 8'h08;
   localparam logic [BYTE_W-1:0] STR_USER = 8'hF4;

   typedef enum logic [REQ_W-1:0] {
      REQ_BMC_READ          = 3'd0,
      REQ_BMC_WRITE         = 3'd1,
      REQ_HOST_DATA_WRITE   = 3'd2,
      REQ_HOST_CMD_WRITE    = 3'd3,
      REQ_HOST_DATA_READ    = 3'd4,
      REQ_HOST_STATUS_READ  = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_DISABLED = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CH_NONE,
      CH_IDR_READ,
      CH_ODR_WRITE,
      CH_STR_WRITE,
      CH_HOST_DATA,
      CH_HOST_CMD,
      CH_ODR_READ
   } chan_op_type;

   typedef struct packed {
      chan_op_type       op;
      logic [BYTE_W-1:0] wbyte;
   } chan_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] idr;
      logic [BYTE_W-1:0] odr;
      logic [BYTE_W-1:0] str;
      logic              ibf_in;
   } chan_view_type;

endpackage

FILE: rtl/kcs_bmc_host_interface.sv
// ----------------------------------------------------------------------------
// KCS BMC/host mailbox
// Three-channel keyboard-controller-style mailbox over a word register file.
// ----------------------------------------------------------------------------
// Usage: one request beat is taken at a rising edge with start high and busy
// low. The request carries req_type, req_reg_index (BMC word offset),
// req_channel (host channel) and req_wdata. Every request, including an
// undefined one, yields exactly one response beat: rsp_valid is high for one
// cycle with rsp_rdata, rsp_status and rsp_irq_level.
// Response path: the request edge reads the register store into the first stage,
// and the result register then holds the response beat.
// Throughput: one request per cycle, sustained while busy is low; requests overlap
// in the two stages and state updates are seen by the very next request.
// The general words live in a single-port RAM addressed at the request edge;
// control, data and status words of the channels are flip-flops.
// Reset: synchronous. All words clear to zero except LADR12L, which reads as
// its reset value until written. busy is high in reset and the cycle after.
// The receiver cannot stall: every response beat must be taken when shown.
// ----------------------------------------------------------------------------
`include "kcs_bmc_host_interface_defines.svh"

module kcs_bmc_host_interface
   import kcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [IDX_W-1:0]    req_reg_index,
   input  logic [CH_W-1:0]     req_channel,
   input  logic [WORD_W-1:0]   req_wdata,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_rdata,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_irq_level
);

   function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
      return {1'b0, idx} < REG_COUNT_IDX;
   endfunction

   function automatic logic idx_general(input logic [IDX_W-1:0] idx);
      return !(idx inside {W_HICR0, W_HICR2, W_HICR4, [W_IDR:W_STR_END]});
   endfunction

   function automatic logic chan_on(input logic [CH_W-1:0]   ch,
                                    input logic [WORD_W-1:0] h0,
                                    input logic [WORD_W-1:0] h4);
      logic on;
      case (ch)
         2'd0:    on = h0[HICR0_EN_LSB];
         2'd1:    on = h0[HICR0_EN_LSB + 1];
         2'd2:    on = h0[HICR0_EN_LSB + 2] && h4[HICR4_KCS_BIT];
         default: on = 1'b0;
      endcase
      return on;
   endfunction

   logic busy_ff;
   logic accept;

   // Register store access at the request edge
   logic                  ram_we;
   logic [RAM_ADDR_W-1:0] ram_addr;
   logic [WORD_W-1:0]     ram_rdata;
   logic [REG_COUNT-1:0]  valid_ff, valid_in;

   // First stage
   logic                s1_valid_ff;
   req_code_type        s1_type_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [CH_W-1:0]     s1_ch_ff;
   logic [WORD_W-1:0]   s1_wdata_ff;
   logic                s1_rd_valid_ff;

   logic [WORD_W-1:0] hicr0_ff, hicr0_in;
   logic [WORD_W-1:0] hicr2_ff, hicr2_in;
   logic [WORD_W-1:0] hicr4_ff, hicr4_in;

   chan_cmd_type  chan_cmd  [NCHAN];
   chan_view_type chan_view [NCHAN];

   logic [WORD_W-1:0] general_rd;
   logic              host_on;
   logic [WORD_W-1:0] rdata_in;
   status_type        status_in;
   logic              irq_in;

   // Result register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_rdata_ff;
   status_type        rsp_status_ff;
   logic              rsp_irq_ff;

   assign accept   = start && !busy_ff;
   assign ram_addr = req_reg_index[RAM_ADDR_W-1:0];
   assign ram_we   = accept && (req_type == REQ_BMC_WRITE) &&
                     idx_in_range(req_reg_index) && idx_general(req_reg_index);

   // General words take the write data unchanged, so they are written at once.
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[ram_addr] = 1'b1;
      end
   end

   kcs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (REG_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_wdata),
      .rdata (ram_rdata)
   );

   for (genvar c = 0; c < NCHAN; c++) begin : g_chan
      kcs_chan u_chan (
         .clock (clock),
         .reset (reset),
         .cmd   (chan_cmd[c]),
         .view  (chan_view[c])
      );
   end

   always_comb begin
      for (int c = 0; c < NCHAN; c++) begin
         chan_cmd[c].op    = CH_NONE;
         chan_cmd[c].wbyte = s1_wdata_ff[BYTE_W-1:0];
      end
      hicr0_in  = hicr0_ff;
      hicr2_in  = hicr2_ff;
      hicr4_in  = hicr4_ff;
      rdata_in  = '0;
      status_in = ST_OK;
      host_on   = chan_on(s1_ch_ff, hicr0_ff, hicr4_ff);

      // A general word never written reads as its reset value.
      if (s1_rd_valid_ff) begin
         general_rd = ram_rdata;
      end else if (s1_idx_ff == W_LADR12L) begin
         general_rd = WORD_W'(LADR12L_RESET);
      end else begin
         general_rd = '0;
      end

      if (s1_valid_ff) begin
         case (s1_type_ff)
            REQ_BMC_READ: begin
               if (!idx_in_range(s1_idx_ff)) begin
                  status_in = ST_RANGE;
               end else begin
                  rdata_in = general_rd;
                  if (s1_idx_ff == W_HICR0) rdata_in = hicr0_ff;
                  if (s1_idx_ff == W_HICR2) rdata_in = hicr2_ff;
                  if (s1_idx_ff == W_HICR4) rdata_in = hicr4_ff;
                  for (int c = 0; c < NCHAN; c++) begin
                     if (s1_idx_ff == W_IDR + IDX_W'(c)) begin
                        rdata_in       = WORD_W'(chan_view[c].idr);
                        chan_cmd[c].op = CH_IDR_READ;
                     end
                     if (s1_idx_ff == W_ODR + IDX_W'(c)) begin
                        rdata_in = WORD_W'(chan_view[c].odr);
                     end
                     if (s1_idx_ff == W_STR + IDX_W'(c)) begin
                        rdata_in = WORD_W'(chan_view[c].str);
                     end
                  end
               end
            end
            REQ_BMC_WRITE: begin
               if (!idx_in_range(s1_idx_ff)) begin
                  status_in = ST_RANGE;
               end else begin
                  if (s1_idx_ff == W_HICR0) hicr0_in = s1_wdata_ff;
                  if (s1_idx_ff == W_HICR2) hicr2_in = s1_wdata_ff;
                  if (s1_idx_ff == W_HICR4) hicr4_in = s1_wdata_ff;
                  for (int c = 0; c < NCHAN; c++) begin
                     if (s1_idx_ff == W_IDR + IDX_W'(c)) begin
                        status_in = ST_DROPPED;
                     end
                     if (s1_idx_ff == W_ODR + IDX_W'(c)) begin
                        chan_cmd[c].op = CH_ODR_WRITE;
                     end
                     if (s1_idx_ff == W_STR + IDX_W'(c)) begin
                        chan_cmd[c].op = CH_STR_WRITE;
                     end
                  end
               end
            end
            REQ_HOST_DATA_WRITE, REQ_HOST_CMD_WRITE,
            REQ_HOST_DATA_READ, REQ_HOST_STATUS_READ: begin
               if (!host_on) begin
                  status_in = ST_DISABLED;
               end else begin
                  for (int c = 0; c < NCHAN; c++) begin
                     if (s1_ch_ff == CH_W'(c)) begin
                        case (s1_type_ff)
                           REQ_HOST_DATA_WRITE: chan_cmd[c].op = CH_HOST_DATA;
                           REQ_HOST_CMD_WRITE:  chan_cmd[c].op = CH_HOST_CMD;
                           REQ_HOST_DATA_READ: begin
                              chan_cmd[c].op = CH_ODR_READ;
                              rdata_in       = WORD_W'(chan_view[c].odr);
                           end
                           default: begin
                              rdata_in = WORD_W'(chan_view[c].str);
                           end
                        endcase
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The interrupt level reflects the state left behind by this beat.
   always_comb begin
      irq_in = 1'b0;
      for (int c = 0; c < NCHAN; c++) begin
         if (chan_view[c].ibf_in && hicr2_in[HICR2_IE_LSB + c] &&
             chan_on(CH_W'(c), hicr0_in, hicr4_in)) begin
            irq_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         hicr0_ff     <= '0;
         hicr2_ff     <= '0;
         hicr4_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         valid_ff     <= valid_in;
         s1_valid_ff  <= accept;
         hicr0_ff     <= hicr0_in;
         hicr2_ff     <= hicr2_in;
         hicr4_ff     <= hicr4_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_type_ff     <= req_code_type'(req_type);
      s1_idx_ff      <= req_reg_index;
      s1_ch_ff       <= req_channel;
      s1_wdata_ff    <= req_wdata;
      s1_rd_valid_ff <= valid_ff[ram_addr];
      rsp_rdata_ff   <= rdata_in;
      rsp_status_ff  <= status_in;
      rsp_irq_ff     <= irq_in;
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rdata     = rsp_rdata_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_irq_level = rsp_irq_ff;

   `KCS_ASSERT_NEXT(a_rsp_follows, s1_valid_ff, rsp_valid_ff, "response beat missing")
   `KCS_ASSERT_NEXT(a_rsp_spurious, !s1_valid_ff, !rsp_valid_ff, "response beat invented")
   `KCS_ASSERT_NOW(a_err_zero, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_rdata_ff == '0, "error response with data")
   `KCS_ASSERT_NOW(a_irq_off, rsp_valid_ff && (hicr0_ff[HICR0_EN_LSB +: NCHAN] == '0), !rsp_irq_ff, "interrupt with all channels disabled")

endmodule

FILE: rtl/kcs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, a write also reading the old word; read data registered.
// ----------------------------------------------------------------------------
module kcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/kcs_chan.sv
// ----------------------------------------------------------------------------
// KCS channel
// Data in, data out and status registers of one channel with flag updates.
// ----------------------------------------------------------------------------
module kcs_chan
   import kcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chan_cmd_type  cmd,
   output chan_view_type view
);

   logic [BYTE_W-1:0] idr_ff, idr_in;
   logic [BYTE_W-1:0] odr_ff, odr_in;
   logic [BYTE_W-1:0] str_ff, str_in;

   always_comb begin
      idr_in = idr_ff;
      odr_in = odr_ff;
      str_in = str_ff;
      case (cmd.op)
         CH_IDR_READ: begin
            str_in = str_ff & ~STR_IBF;
         end
         CH_ODR_WRITE: begin
            odr_in = cmd.wbyte;
            str_in = str_ff | STR_OBF;
         end
         CH_STR_WRITE: begin
            // Only the user bits follow the write; OBF can be cleared but not set.
            str_in = (str_ff & ~STR_USER) | (cmd.wbyte & STR_USER);
            if ((cmd.wbyte & STR_OBF) == '0) begin
               str_in = str_in & ~STR_OBF;
            end
         end
         CH_HOST_DATA: begin
            idr_in = cmd.wbyte;
            str_in = (str_ff | STR_IBF) & ~STR_CD;
         end
         CH_HOST_CMD: begin
            idr_in = cmd.wbyte;
            str_in = str_ff | STR_IBF | STR_CD;
         end
         CH_ODR_READ: begin
            str_in = str_ff & ~STR_OBF;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idr_ff <= '0;
         odr_ff <= '0;
         str_ff <= '0;
      end else begin
         idr_ff <= idr_in;
         odr_ff <= odr_in;
         str_ff <= str_in;
      end
   end

   assign view.idr    = idr_ff;
   assign view.odr    = odr_ff;
   assign view.str    = str_ff;
   assign view.ibf_in = (str_in & STR_IBF) != '0;

endmodule

FILE: dv/kcs_bmc_host_interface_tb.sv
// ----------------------------------------------------------------------------
// KCS mailbox testbench
// Drives BMC register and host port beats into the three-channel mailbox.
// A scoreboard predicts the response of each accepted beat from its own copy
// of the word store and checks every response beat field by field. A directed
// opening covers the flag and error cases. Random mailbox exchanges and noise
// follow, in four phases with sender idling of 0, 53, 0 and 17 percent.
// ----------------------------------------------------------------------------
module kcs_bmc_host_interface_tb;
   import kcs_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;
   localparam logic [CH_W-1:0]  CH_INVALID   = 2'd3;

   localparam logic [WORD_W-1:0] OBF_W  = WORD_W'(STR_OBF);
   localparam logic [WORD_W-1:0] IBF_W  = WORD_W'(STR_IBF);
   localparam logic [WORD_W-1:0] CD_W   = WORD_W'(STR_CD);
   localparam logic [WORD_W-1:0] USER_W = WORD_W'(STR_USER);
   localparam logic [WORD_W-1:0] BYTE_MASK = 32'h0000_00FF;
   localparam logic [WORD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] HICR0_ALL = 32'h0000_00E0;
   localparam logic [WORD_W-1:0] HICR2_ALL = 32'h0000_000E;
   localparam logic [WORD_W-1:0] HICR4_ON  = 32'h0000_0004;

   localparam int PHASE_ITEMS = 375;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;

   typedef struct {
      logic [WORD_W-1:0]   rdata;
      logic [STATUS_W-1:0] status;
      logic                irq;
   } mbox_rsp_type;

   class kcs_mailbox_scoreboard;
      logic [WORD_W-1:0] words [REG_COUNT];
      mbox_rsp_type      pending_rsp [$];
      int                errors;
      int                checked;

      function new();
         foreach (words[i]) words[i] = '0;
         words[W_LADR12L] = WORD_W'(LADR12L_RESET);
         errors  = 0;
         checked = 0;
      endfunction

      task report(string msg);
         $display("mismatch at response %0d: %s", checked, msg);
         errors++;
      endtask

      function int pending();
         return pending_rsp.size();
      endfunction

      function bit channel_open(logic [CH_W-1:0] ch);
         if (ch >= NCHAN) return 1'b0;
         if (!words[W_HICR0][HICR0_EN_LSB + ch]) return 1'b0;
         if (ch == 2 && !words[W_HICR4][HICR4_KCS_BIT]) return 1'b0;
         return 1'b1;
      endfunction

      function logic irq_line();
         for (int c = 0; c < NCHAN; c++) begin
            if (words[W_STR + c][1] && words[W_HICR2][HICR2_IE_LSB + c] &&
                channel_open(CH_W'(c)))
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                 logic [CH_W-1:0] ch, logic [WORD_W-1:0] wd);
         mbox_rsp_type      r;
         logic [WORD_W-1:0] s;
         r.rdata  = '0;
         r.status = ST_OK;
         case (req)
            REQ_BMC_READ, REQ_BMC_WRITE: begin
               if (idx >= REG_COUNT) begin
                  r.status = ST_RANGE;
               end else if (req == REQ_BMC_READ) begin
                  // Reading an input data word hands the byte over to the BMC.
                  if (idx >= W_IDR && idx < W_IDR + NCHAN)
                     words[W_STR + (idx - W_IDR)] &= ~IBF_W;
                  r.rdata = words[idx];
               end else if (idx >= W_IDR && idx < W_IDR + NCHAN) begin
                  r.status = ST_DROPPED;
               end else if (idx >= W_ODR && idx < W_ODR + NCHAN) begin
                  words[idx] = wd & BYTE_MASK;
                  words[W_STR + (idx - W_ODR)] |= OBF_W;
               end else if (idx >= W_STR && idx <= W_STR_END) begin
                  s = (words[idx] & ~USER_W) | (wd & USER_W);
                  if (!wd[0]) s &= ~OBF_W;
                  words[idx] = s;
               end else begin
                  words[idx] = wd;
               end
            end
            REQ_HOST_DATA_WRITE, REQ_HOST_CMD_WRITE,
            REQ_HOST_DATA_READ, REQ_HOST_STATUS_READ: begin
               if (!channel_open(ch)) begin
                  r.status = ST_DISABLED;
               end else if (req == REQ_HOST_DATA_WRITE || req == REQ_HOST_CMD_WRITE) begin
                  s = words[W_STR + ch] | IBF_W;
                  words[W_IDR + ch] = wd & BYTE_MASK;
                  if (req == REQ_HOST_CMD_WRITE) s |= CD_W;
                  else s &= ~CD_W;
                  words[W_STR + ch] = s;
               end else if (req == REQ_HOST_DATA_READ) begin
                  r.rdata = words[W_ODR + ch] & BYTE_MASK;
                  words[W_STR + ch] &= ~OBF_W;
               end else begin
                  r.rdata = words[W_STR + ch] & BYTE_MASK;
               end
            end
            default: ;
         endcase
         r.irq = irq_line();
         pending_rsp.push_back(r);
      endfunction

      task check_response(logic [WORD_W-1:0] rdata, logic [STATUS_W-1:0] status,
                          logic irq);
         mbox_rsp_type e;
         if (pending_rsp.size() == 0) begin
            report("response beat with nothing outstanding");
            return;
         end
         e = pending_rsp.pop_front();
         if (rdata !== e.rdata)
            report($sformatf("rdata %h, expected %h", rdata, e.rdata));
         if (status !== e.status)
            report($sformatf("status %0d, expected %0d", status, e.status));
         if (irq !== e.irq)
            report($sformatf("irq_level %b, expected %b", irq, e.irq));
         checked++;
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [IDX_W-1:0]    req_reg_index;
   logic [CH_W-1:0]     req_channel;
   logic [WORD_W-1:0]   req_wdata;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_rdata;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_irq_level;

   kcs_mailbox_scoreboard sb = new();
   int cycle_count = 0;
   int items_sent  = 0;

   kcs_bmc_host_interface u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_reg_index (req_reg_index),
      .req_channel   (req_channel),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_rdata     (rsp_rdata),
      .rsp_status    (rsp_status),
      .rsp_irq_level (rsp_irq_level)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Responses are checked before the beat taken at the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_rdata, rsp_status, rsp_irq_level);
         if (start && busy === 1'b0)
            sb.note_request(req_type, req_reg_index, req_channel, req_wdata);
      end
   end

   task automatic drive_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                logic [CH_W-1:0] ch, logic [WORD_W-1:0] wd);
      @(negedge clock);
      start         <= 1'b1;
      req_type      <= req;
      req_reg_index <= idx;
      req_channel   <= ch;
      req_wdata     <= wd;
      do @(posedge clock); while (busy !== 1'b0);
      if (req <= REQ_HOST_STATUS_READ) items_sent++;
   endtask

   task automatic idle_for(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic maybe_idle(int pct);
      if ($urandom_range(1, 100) <= pct) idle_for($urandom_range(1, 4));
   endtask

   // Holds the sender off until every outstanding response beat has arrived.
   task automatic drain();
      idle_for(1);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return IDX_W'($urandom_range(0, W_STR_END));
      if (r < 9) return IDX_W'($urandom_range(0, REG_COUNT - 1));
      return IDX_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [CH_W-1:0] pick_channel();
      if ($urandom_range(0, 9) == 0) return CH_INVALID;
      return CH_W'($urandom_range(0, NCHAN - 1));
   endfunction

   function automatic logic [WORD_W-1:0] pick_data();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_one(int pct);
      logic [REQ_W-1:0]  req;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] wd;
      req = ($urandom_range(0, 19) == 0) ? REQ_W'($urandom_range(6, 7))
                                         : REQ_W'($urandom_range(0, 5));
      idx = pick_index();
      wd  = pick_data();
      // Keep the channels open most of the time so that host beats get through.
      if (req == REQ_BMC_WRITE && $urandom_range(0, 3) != 0) begin
         if (idx == W_HICR0) wd |= HICR0_ALL;
         if (idx == W_HICR2) wd |= HICR2_ALL;
         if (idx == W_HICR4) wd |= HICR4_ON;
      end
      drive_request(req, idx, pick_channel(), wd);
      maybe_idle(pct);
   endtask

   // One round trip of the mailbox protocol on one channel.
   task automatic mailbox_exchange(int pct);
      logic [CH_W-1:0] ch;
      logic [REQ_W-1:0] wr;
      ch = pick_channel();
      wr = $urandom_range(0, 1) ? REQ_HOST_CMD_WRITE : REQ_HOST_DATA_WRITE;
      drive_request(wr, '0, ch, pick_data());
      maybe_idle(pct);
      drive_request(REQ_BMC_READ, W_STR + ch, ch, pick_data());
      maybe_idle(pct);
      drive_request(REQ_BMC_READ, W_IDR + ch, ch, pick_data());
      maybe_idle(pct);
      if ($urandom_range(0, 3) == 0) begin
         drive_request(REQ_BMC_WRITE, W_STR + ch, ch, pick_data());
         maybe_idle(pct);
      end
      drive_request(REQ_BMC_WRITE, W_ODR + ch, ch, pick_data());
      maybe_idle(pct);
      drive_request(REQ_HOST_STATUS_READ, pick_index(), ch, pick_data());
      maybe_idle(pct);
      drive_request(REQ_HOST_DATA_READ, pick_index(), ch, pick_data());
      maybe_idle(pct);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int idle_pct [4];
      int goal;
      idle_pct = '{0, 53, 0, 17};
      reset         <= 1'b1;
      start         <= 1'b0;
      req_type      <= REQ_BMC_READ;
      req_reg_index <= '0;
      req_channel   <= '0;
      req_wdata     <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values, closed channels and out of range words.
      drive_request(REQ_BMC_READ, W_LADR12L, '0, '0);
      drive_request(REQ_BMC_READ, W_HICR0, '0, '0);
      drive_request(REQ_HOST_STATUS_READ, '0, 2'd0, '0);
      drive_request(REQ_HOST_DATA_WRITE, '0, CH_INVALID, ALL_ONES);
      drive_request(REQ_BMC_READ, IDX_W'(1023), '0, '0);
      drive_request(REQ_BMC_WRITE, IDX_W'(REG_COUNT), '0, ALL_ONES);
      drive_request(REQ_BMC_WRITE, IDX_W'(1023), CH_INVALID, ALL_ONES);
      // Open all three channels with interrupts on.
      drive_request(REQ_BMC_WRITE, W_HICR0, '0, ALL_ONES);
      drive_request(REQ_BMC_WRITE, W_HICR4, '0, HICR4_ON);
      drive_request(REQ_BMC_WRITE, W_HICR2, '0, HICR2_ALL);
      drive_request(REQ_HOST_DATA_WRITE, '0, 2'd0, ALL_ONES);
      drive_request(REQ_HOST_STATUS_READ, '0, 2'd0, '0);
      drive_request(REQ_BMC_READ, W_IDR, '0, '0);
      drive_request(REQ_HOST_CMD_WRITE, '0, 2'd1, 32'h0000_00A5);
      drive_request(REQ_BMC_WRITE, W_IDR + 1, '0, ALL_ONES);
      drive_request(REQ_BMC_WRITE, W_ODR + 2, '0, ALL_ONES);
      drive_request(REQ_HOST_DATA_READ, '0, 2'd2, '0);
      // Status writes touch only the user bits, and a zero in bit 0 clears OBF.
      drive_request(REQ_BMC_WRITE, W_ODR, '0, 32'h0000_005A);
      drive_request(REQ_BMC_WRITE, W_STR, '0, ALL_ONES);
      drive_request(REQ_BMC_WRITE, W_STR, '0, '0);
      drive_request(REQ_HOST_CMD_WRITE, '0, 2'd2, '0);
      drive_request(REQ_BMC_WRITE, W_HICR4, '0, '0);
      drive_request(REQ_HOST_STATUS_READ, '0, 2'd2, '0);
      drive_request(REQ_UNDEF_LO, IDX_W'(1023), CH_INVALID, ALL_ONES);
      drive_request(REQ_UNDEF_HI, '0, '0, '0);
      drive_request(REQ_BMC_WRITE, IDX_W'(REG_COUNT - 1), '0, ALL_ONES);
      drive_request(REQ_BMC_READ, IDX_W'(REG_COUNT - 1), '0, '0);
      drain();

      foreach (idle_pct[p]) begin
         drive_request(REQ_BMC_WRITE, W_HICR0, '0, HICR0_ALL | ($urandom & 32'h1F));
         drive_request(REQ_BMC_WRITE, W_HICR4, '0, HICR4_ON);
         drive_request(REQ_BMC_WRITE, W_HICR2, '0, HICR2_ALL);
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 4) mailbox_exchange(idle_pct[p]);
            else random_one(idle_pct[p]);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/kcs_pkg.sv
rtl/kcs_ram.sv
rtl/kcs_chan.sv
rtl/kcs_bmc_host_interface.sv
dv/kcs_bmc_host_interface_tb.sv
